FILE: rtl/brd_pkg.sv
package brd_pkg;

    localparam int MAX_ROW_BYTES = 4096;
    localparam int OUT_BYTES     = 4;

    localparam int ROW_W      = 13;
    localparam int SRC_W      = 24;
    localparam int RUN_W      = 8;
    localparam int DATA_W     = 32;
    localparam int CNT_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // request types
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_BYTE  = 1'b1;

    // decode modes
    localparam logic MODE_RAW = 1'b0;
    localparam logic MODE_RUN = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE          = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_LENGTH = 2'd2;

    localparam logic             MODE_RESET      = MODE_RUN;
    localparam logic [ROW_W-1:0] ROW_BYTES_RESET = 13'd40;

    localparam logic [RUN_W-1:0] HDR_NOP = 8'h80;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_LITERAL = 2'd1,
        PH_REPEAT  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_SOURCE = 2'd1,
        ERR_ROW    = 2'd2
    } err_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic take;   // input transfer this cycle
        logic emit;   // load next repeat word into output register
    } brd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic one_result;  // current input gives exactly one result
        logic repeat_run;  // current input starts a repeat run
        logic run_last;    // next repeat word is the final one
    } brd_stat_t;

endpackage

FILE: rtl/brd_ifs.sv
interface brd_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] in_byte;

    modport source (output valid, output req_type, output in_byte, input ready);
    modport sink   (input valid, input req_type, input in_byte, output ready);
endinterface

interface brd_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_data;
    logic [2:0]  byte_count;
    logic        row_end;
    logic [1:0]  error_code;
    logic        last;

    modport source (output valid, output out_data, output byte_count, output row_end,
                    output error_code, output last, input ready);
    modport sink   (input valid, input out_data, input byte_count, input row_end,
                    input error_code, input last, output ready);
endinterface

FILE: rtl/brd_ctrl.sv
module brd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  brd_pkg::brd_stat_t stat,
    output brd_pkg::brd_cmd_t  cmd
);

    brd_pkg::ctrl_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;
    logic load;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == brd_pkg::ST_IDLE) && out_free;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd.take   = 1'b0;
        cmd.emit   = 1'b0;
        load       = 1'b0;
        case (state_reg)
            brd_pkg::ST_IDLE:
            begin
                cmd.take = in_valid && out_free;
                if (cmd.take)
                begin
                    if (stat.one_result)
                        load = 1'b1;
                    else if (stat.repeat_run)
                        state_next = brd_pkg::ST_RUN;
                end
            end
            brd_pkg::ST_RUN:
            begin
                if (out_free)
                begin
                    cmd.emit = 1'b1;
                    load     = 1'b1;
                    if (stat.run_last)
                        state_next = brd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = brd_pkg::ST_IDLE;
            end
        endcase
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= brd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/brd_datapath.sv
module brd_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [brd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [brd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              req_type,
    input  logic [7:0]                        in_byte,
    input  brd_pkg::brd_cmd_t                 cmd,
    output brd_pkg::brd_stat_t                stat,
    output logic [brd_pkg::DATA_W-1:0]        out_data,
    output logic [brd_pkg::CNT_W-1:0]         byte_count,
    output logic                              row_end,
    output logic [1:0]                        error_code,
    output logic                              last
);

    localparam int ROW_W = brd_pkg::ROW_W;
    localparam int SRC_W = brd_pkg::SRC_W;
    localparam int RUN_W = brd_pkg::RUN_W;
    localparam int CNT_W = brd_pkg::CNT_W;

    // configuration
    logic             mode_reg;
    logic [ROW_W-1:0] row_bytes_reg;
    logic [SRC_W-1:0] source_length_reg;

    // decode state
    logic [SRC_W-1:0] source_left_reg, source_left_next;
    logic [ROW_W-1:0] row_left_reg, row_left_next;
    logic             row_wrap_reg, row_wrap_next;
    brd_pkg::phase_t  phase_reg, phase_next;
    logic [RUN_W-1:0] run_left_reg, run_left_next;
    brd_pkg::err_t    error_reg, error_next;
    logic [RUN_W-1:0] repeat_count_reg, repeat_count_next;
    logic [RUN_W-1:0] rep_left_reg, rep_left_next;
    logic [7:0]       rep_byte_reg, rep_byte_next;

    // output word
    logic [brd_pkg::DATA_W-1:0] out_data_reg, res_data, emit_data;
    logic [CNT_W-1:0]           out_cnt_reg, res_cnt;
    logic                       out_row_end_reg, res_row_end;
    brd_pkg::err_t              out_err_reg, res_err;
    logic                       out_last_reg;

    logic             one_result, repeat_run;
    logic             row_zero;
    logic [ROW_W-1:0] row_len, eff_row, eff_row_dec;
    logic [SRC_W-1:0] src_dec;
    logic [RUN_W-1:0] lit_cnt, rep_cnt, run_dec;

    // repeat word
    logic [CNT_W-1:0] emit_n;
    logic [RUN_W-1:0] emit_rem;
    logic [ROW_W:0]   emit_row;
    logic             emit_borrow;

    always_comb
    begin
        if (row_bytes_reg < ROW_W'(2))
            row_len = ROW_W'(2);
        else if (row_bytes_reg > ROW_W'(brd_pkg::MAX_ROW_BYTES))
            row_len = ROW_W'(brd_pkg::MAX_ROW_BYTES);
        else
            row_len = row_bytes_reg;
    end

    assign row_zero    = (row_left_reg == '0) && !row_wrap_reg;
    assign eff_row     = row_zero ? row_len : row_left_reg;
    assign eff_row_dec = eff_row - ROW_W'(1);
    assign src_dec     = source_left_reg - SRC_W'(1);
    assign lit_cnt     = {1'b0, in_byte[6:0]} + RUN_W'(1);
    assign rep_cnt     = (RUN_W'(0) - in_byte) + RUN_W'(1);
    assign run_dec     = run_left_reg - RUN_W'(1);

    // item decode, evaluated for the byte at the input
    always_comb
    begin
        source_left_next  = source_left_reg;
        row_left_next     = row_left_reg;
        row_wrap_next     = row_wrap_reg;
        phase_next        = phase_reg;
        run_left_next     = run_left_reg;
        error_next        = error_reg;
        repeat_count_next = repeat_count_reg;
        rep_byte_next     = rep_byte_reg;
        one_result        = 1'b0;
        repeat_run        = 1'b0;
        res_data          = '0;
        res_cnt           = '0;
        res_row_end       = 1'b0;
        res_err           = brd_pkg::ERR_NONE;

        if (req_type == brd_pkg::REQ_START)
        begin
            source_left_next = source_length_reg;
            row_left_next    = '0;
            row_wrap_next    = 1'b0;
            phase_next       = brd_pkg::PH_HEADER;
            run_left_next    = '0;
            error_next       = brd_pkg::ERR_NONE;
        end
        else if (error_reg != brd_pkg::ERR_NONE)
        begin
            one_result = 1'b1;
            res_err    = error_reg;
        end
        else if (row_zero && mode_reg == brd_pkg::MODE_RAW
                 && source_left_reg < SRC_W'(row_len))
        begin
            one_result = 1'b1;
            res_err    = brd_pkg::ERR_SOURCE;
            error_next = brd_pkg::ERR_SOURCE;
        end
        else
        begin
            row_left_next = eff_row;
            if (source_left_reg == '0)
            begin
                one_result = 1'b1;
                res_err    = brd_pkg::ERR_SOURCE;
                error_next = brd_pkg::ERR_SOURCE;
            end
            else if (mode_reg == brd_pkg::MODE_RAW || phase_reg == brd_pkg::PH_LITERAL)
            begin
                source_left_next = src_dec;
                row_left_next    = eff_row_dec;
                one_result       = 1'b1;
                res_data         = {{(brd_pkg::DATA_W-8){1'b0}}, in_byte};
                res_cnt          = CNT_W'(1);
                res_row_end      = !row_wrap_reg && (eff_row_dec == '0);
                if (mode_reg == brd_pkg::MODE_RUN)
                begin
                    run_left_next = run_dec;
                    if (run_dec == '0)
                        phase_next = brd_pkg::PH_HEADER;
                end
            end
            else
            begin
                source_left_next = src_dec;
                case (phase_reg)
                    brd_pkg::PH_REPEAT:
                    begin
                        phase_next    = brd_pkg::PH_HEADER;
                        rep_byte_next = in_byte;
                        repeat_run    = 1'b1;
                    end
                    brd_pkg::PH_HEADER:
                    begin
                        if (!in_byte[7])
                        begin
                            if (src_dec < SRC_W'(lit_cnt))
                            begin
                                one_result = 1'b1;
                                res_err    = brd_pkg::ERR_SOURCE;
                                error_next = brd_pkg::ERR_SOURCE;
                            end
                            else if (!row_wrap_reg && eff_row < ROW_W'(lit_cnt))
                            begin
                                one_result = 1'b1;
                                res_err    = brd_pkg::ERR_ROW;
                                error_next = brd_pkg::ERR_ROW;
                            end
                            else
                            begin
                                run_left_next = lit_cnt;
                                phase_next    = brd_pkg::PH_LITERAL;
                            end
                        end
                        else if (in_byte != brd_pkg::HDR_NOP)
                        begin
                            if (src_dec == '0)
                            begin
                                one_result = 1'b1;
                                res_err    = brd_pkg::ERR_SOURCE;
                                error_next = brd_pkg::ERR_SOURCE;
                            end
                            else if (!row_wrap_reg && eff_row < ROW_W'(rep_cnt))
                            begin
                                one_result = 1'b1;
                                res_err    = brd_pkg::ERR_ROW;
                                error_next = brd_pkg::ERR_ROW;
                            end
                            else
                            begin
                                repeat_count_next = rep_cnt;
                                phase_next        = brd_pkg::PH_REPEAT;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // next word of a repeat run
    always_comb
    begin
        if (rep_left_reg < RUN_W'(brd_pkg::OUT_BYTES))
            emit_n = rep_left_reg[CNT_W-1:0];
        else
            emit_n = CNT_W'(brd_pkg::OUT_BYTES);
        emit_rem    = rep_left_reg - RUN_W'(emit_n);
        emit_row    = {1'b0, row_left_reg} - (ROW_W+1)'(emit_n);
        emit_borrow = emit_row[ROW_W];
        emit_data   = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (CNT_W'(i) < emit_n)
                emit_data[8*i +: 8] = rep_byte_reg;
        end
    end

    assign rep_left_next = cmd.take ? repeat_count_reg : emit_rem;

    assign stat.one_result = one_result;
    assign stat.repeat_run = repeat_run;
    assign stat.run_last   = (rep_left_reg <= RUN_W'(brd_pkg::OUT_BYTES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= brd_pkg::MODE_RESET;
            row_bytes_reg     <= brd_pkg::ROW_BYTES_RESET;
            source_length_reg <= '0;
            source_left_reg   <= '0;
            row_left_reg      <= '0;
            row_wrap_reg      <= 1'b0;
            phase_reg         <= brd_pkg::PH_HEADER;
            run_left_reg      <= '0;
            error_reg         <= brd_pkg::ERR_NONE;
            repeat_count_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    brd_pkg::CFG_MODE:          mode_reg          <= cfg_data[0];
                    brd_pkg::CFG_ROW_BYTES:     row_bytes_reg     <= cfg_data[ROW_W-1:0];
                    brd_pkg::CFG_SOURCE_LENGTH: source_length_reg <= cfg_data[SRC_W-1:0];
                    default:                    mode_reg          <= mode_reg;
                endcase
            end
            if (cmd.take)
            begin
                source_left_reg  <= source_left_next;
                row_left_reg     <= row_left_next;
                row_wrap_reg     <= row_wrap_next;
                phase_reg        <= phase_next;
                run_left_reg     <= run_left_next;
                error_reg        <= error_next;
                repeat_count_reg <= repeat_count_next;
            end
            else if (cmd.emit)
            begin
                row_left_reg <= emit_row[ROW_W-1:0];
                row_wrap_reg <= row_wrap_reg || emit_borrow;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            rep_byte_reg <= rep_byte_next;
            rep_left_reg <= rep_left_next;
            if (one_result)
            begin
                out_data_reg    <= res_data;
                out_cnt_reg     <= res_cnt;
                out_row_end_reg <= res_row_end;
                out_err_reg     <= res_err;
                out_last_reg    <= 1'b1;
            end
        end
        else if (cmd.emit)
        begin
            rep_left_reg    <= rep_left_next;
            out_data_reg    <= emit_data;
            out_cnt_reg     <= emit_n;
            out_row_end_reg <= (emit_rem == '0) && (emit_row == '0) && !row_wrap_reg;
            out_err_reg     <= brd_pkg::ERR_NONE;
            out_last_reg    <= (emit_rem == '0);
        end
    end

    assign out_data   = out_data_reg;
    assign byte_count = out_cnt_reg;
    assign row_end    = out_row_end_reg;
    assign error_code = out_err_reg;
    assign last       = out_last_reg;

endmodule

FILE: rtl/byterun1_row_decoder_core.sv
// ByteRun1 row decoder: expands compressed source bytes into rows of row_bytes
// bytes, either passed through raw (mode 0) or run-length decoded (mode 1).
// A start item on req reloads the source budget from source_length and clears
// a sticky error; it gives no result, nor does a header byte. Raw and literal
// bytes give one result each; a repeat byte gives ceil(count/4) words of up to
// four equal bytes, first byte in bits 7..0, the final one marked by last.
// Once an error is raised (source exhausted or run longer than the row
// remainder) every source byte gives one error result until the next start.
// Rate: one input transfer per cycle while the result register drains; a
// repeat byte holds the input off until its last word is loaded, one word
// per cycle while the single output register is free. Configuration writes
// are to be made while the block idles; the block itself does not enforce it.
module byterun1_row_decoder_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [brd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [brd_pkg::CFG_DATA_W-1:0] cfg_data,
    brd_req_if.sink                        req,
    brd_rsp_if.source                      rsp
);

    // command and status between sequencer and decode datapath
    brd_pkg::brd_cmd_t  cmd;
    brd_pkg::brd_stat_t stat;

    // sequencer: input transfers, repeat word stepping, output register valid
    brd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // decode datapath: config, counters, phase, error and the result word
    brd_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_type   (req.req_type),
        .in_byte    (req.in_byte),
        .cmd        (cmd),
        .stat       (stat),
        .out_data   (rsp.out_data),
        .byte_count (rsp.byte_count),
        .row_end    (rsp.row_end),
        .error_code (rsp.error_code),
        .last       (rsp.last)
    );

endmodule
